// ----- hw/rtl/smm_pkg.sv -----
// Shared types and constants for the square matrix multiply core.
`default_nettype none

package smm_pkg;

  localparam int DefaultMaxDim = 8;

  localparam int CmdW    = 2;
  localparam int IdxPortW = 3;
  localparam int ElemW   = 16;
  localparam int ProdW   = 2 * ElemW;
  localparam int AccW    = 35;
  localparam int SizeW   = 4;
  localparam int InDataW  = 24;
  localparam int OutDataW = 48;

  localparam logic [CmdW-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CmdW-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [SizeW-1:0] SizeReset = 4'd4;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } smm_mac_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/smm_matrix_store.sv -----
// Storage for the left and right operand matrices, one write and one read port each.
`default_nettype none

module smm_matrix_store
  import smm_pkg::*;
#(
  parameter int MAX_DIM = DefaultMaxDim,
  localparam int Depth = MAX_DIM * MAX_DIM,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we_left,
  input  wire logic                    we_right,
  input  wire logic [AddrW-1:0]        waddr,
  input  wire logic signed [ElemW-1:0] wdata,
  input  wire logic [AddrW-1:0]        raddr_left,
  input  wire logic [AddrW-1:0]        raddr_right,
  output logic signed [ElemW-1:0]      rdata_left,
  output logic signed [ElemW-1:0]      rdata_right
);

  logic signed [ElemW-1:0] left_mem  [Depth];
  logic signed [ElemW-1:0] right_mem [Depth];

  always_ff @(posedge clk) begin
    if (we_left) begin
      left_mem[waddr] <= wdata;
    end
    rdata_left <= left_mem[raddr_left];
  end

  always_ff @(posedge clk) begin
    if (we_right) begin
      right_mem[waddr] <= wdata;
    end
    rdata_right <= right_mem[raddr_right];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/smm_mac.sv -----
// Shared multiply-accumulate unit: one registered product and one full-width accumulator.
`default_nettype none

module smm_mac
  import smm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire smm_mac_ctrl_t           ctrl,
  input  wire logic signed [ElemW-1:0] op_a,
  input  wire logic signed [ElemW-1:0] op_b,
  output logic signed [AccW-1:0]       acc,
  output logic                         done
);

  logic signed [ProdW-1:0] prod;
  logic                    prod_valid;
  logic                    prod_first;
  logic                    prod_last;
  logic signed [AccW-1:0]  prod_ext;

  assign prod_ext = {{(AccW - ProdW){prod[ProdW-1]}}, prod};

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
      prod_last  <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
      prod_first <= ctrl.first;
      prod_last  <= ctrl.last;
      done       <= prod_valid && prod_last;
    end
    if (prod_valid) begin
      acc <= prod_first ? prod_ext : acc + prod_ext;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/square_matrix_multiply_core.sv -----
// Top level of the square matrix multiply core: stream ports, sequencer and datapath.
//
// Load items and unused commands are taken while idle and leave the core idle. A
// compute item runs one multiply-accumulate per cycle, while it issues operand
// reads, through a single shared multiplier; each product entry takes n operand
// reads, then the memory read, multiply and accumulate, then an output transfer,
// and a run is held while the output stalls. The input side is not ready in a run.
`default_nettype none

module square_matrix_multiply_core
  import smm_pkg::*;
#(
  parameter int MAX_DIM = DefaultMaxDim
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [SizeW-1:0]     cfg_wr_data,   // active_size
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InDataW-1:0]   s_axis_tdata,  // row_index, col_index, element_value
  input  wire logic [CmdW-1:0]      s_axis_tuser,  // cmd
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,  // out_row, out_col, product_value
  output logic                      m_axis_tlast   // last_of_run
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t               state;
  logic [SizeW-1:0]     active_size;
  logic [IdxW-1:0]      n_last;
  logic [IdxW-1:0]      n_last_next;
  logic [IdxW-1:0]      row_cnt;
  logic [IdxW-1:0]      col_cnt;
  logic [IdxW-1:0]      k_cnt;
  smm_mac_ctrl_t        rd_ctrl;

  logic [IdxPortW-1:0]     in_row;
  logic [IdxPortW-1:0]     in_col;
  logic signed [ElemW-1:0] in_value;
  logic                    in_fire;
  logic                    in_range;
  logic                    we_left;
  logic                    we_right;
  logic [AddrW-1:0]        waddr;
  logic [AddrW-1:0]        raddr_left;
  logic [AddrW-1:0]        raddr_right;
  logic signed [ElemW-1:0] rdata_left;
  logic signed [ElemW-1:0] rdata_right;
  logic signed [AccW-1:0]  acc;
  logic                    mac_done;
  logic                    entry_last;
  logic                    out_fire;

  assign in_row   = s_axis_tdata[IdxPortW-1:0];
  assign in_col   = s_axis_tdata[2*IdxPortW-1:IdxPortW];
  assign in_value = s_axis_tdata[2*IdxPortW+ElemW-1:2*IdxPortW];

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign we_left       = in_fire && in_range && (s_axis_tuser == CMD_LOAD_A);
  assign we_right      = in_fire && in_range && (s_axis_tuser == CMD_LOAD_B);
  assign waddr         = AddrW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign raddr_left    = AddrW'(32'(row_cnt) * MAX_DIM + 32'(k_cnt));
  assign raddr_right   = AddrW'(32'(k_cnt) * MAX_DIM + 32'(col_cnt));

  always_comb begin
    if (active_size == '0) begin
      n_last_next = '0;
    end else if (32'(active_size) > MAX_DIM) begin
      n_last_next = IdxW'(MAX_DIM - 1);
    end else begin
      n_last_next = IdxW'(active_size - 4'd1);
    end
  end

  assign entry_last = (row_cnt == n_last) && (col_cnt == n_last);
  assign out_fire   = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SizeReset;
    end else if (cfg_wr_en) begin
      active_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_ctrl <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
      n_last  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_ctrl <= '0;
          if (in_fire && (s_axis_tuser == CMD_COMPUTE)) begin
            n_last  <= n_last_next;
            row_cnt <= '0;
            col_cnt <= '0;
            k_cnt   <= '0;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          rd_ctrl <= '{valid: 1'b1, first: (k_cnt == '0), last: (k_cnt == n_last)};
          if (k_cnt == n_last) begin
            k_cnt <= '0;
            state <= S_DRAIN;
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          rd_ctrl <= '0;
          if (mac_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          rd_ctrl <= '0;
          if (out_fire) begin
            if (entry_last) begin
              state <= S_IDLE;
            end else begin
              state <= S_ISSUE;
              if (col_cnt == n_last) begin
                col_cnt <= '0;
                row_cnt <= row_cnt + 1'b1;
              end else begin
                col_cnt <= col_cnt + 1'b1;
              end
            end
          end
        end
        default: begin
          rd_ctrl <= '0;
          state   <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_EMIT);
  assign m_axis_tlast  = entry_last;
  assign m_axis_tdata  = {(OutDataW - AccW - 2 * IdxPortW)'(0), acc,
                          IdxPortW'(col_cnt), IdxPortW'(row_cnt)};

  smm_matrix_store #(
    .MAX_DIM(MAX_DIM)
  ) u_store (
    .clk         (clk),
    .we_left     (we_left),
    .we_right    (we_right),
    .waddr       (waddr),
    .wdata       (in_value),
    .raddr_left  (raddr_left),
    .raddr_right (raddr_right),
    .rdata_left  (rdata_left),
    .rdata_right (rdata_right)
  );

  smm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rd_ctrl),
    .op_a (rdata_left),
    .op_b (rdata_right),
    .acc  (acc),
    .done (mac_done)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/smm_checker.sv -----
// Port-level checks for the square matrix multiply core, bound to the top level.
`default_nettype none

module smm_checker
  import smm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [CmdW-1:0]     s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output result changed");

  a_busy_on_output: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_COMPUTE) |=> !s_axis_tready)
    else $error("input ready straight after a compute transfer");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("output continued after last transfer of a run");

endmodule

bind square_matrix_multiply_core smm_checker u_smm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
